[sv/ets_pkg.sv]
// ----------------------------------------------------------------------------
// ets_pkg
// Shared types, constants and character classes of the expression token
// scanner.
// ----------------------------------------------------------------------------
package ets_pkg;

    localparam int POSITION_WIDTH_DEFAULT = 32;
    localparam int LENGTH_WIDTH_DEFAULT   = 16;

    localparam int START_BITS  = 32;
    localparam int LENGTH_BITS = 16;
    localparam int KIND_BITS   = 4;
    localparam int CHAR_BITS   = 8;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DIG0   = 8'h30;
    localparam logic [7:0] CH_DIG9   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_SUM    = 4'd0,
        KIND_MUL    = 4'd1,
        KIND_POW    = 4'd2,
        KIND_LPAREN = 4'd3,
        KIND_RPAREN = 4'd4,
        KIND_EQUAL  = 4'd5,
        KIND_NUMBER = 4'd6,
        KIND_SYMBOL = 4'd7,
        KIND_END    = 4'd8,
        KIND_ERROR  = 4'd9
    } kind_t;

    typedef enum logic [2:0] {
        ST_START = 3'd0,
        ST_INT   = 3'd1,
        ST_PRE   = 3'd2,
        ST_REAL  = 3'd3,
        ST_SYM   = 3'd4,
        ST_END   = 3'd5,
        ST_ERR   = 3'd6
    } scan_state_t;

    typedef struct packed {
        kind_t                  kind;
        logic [START_BITS-1:0]  start;
        logic [LENGTH_BITS-1:0] length;
        logic [CHAR_BITS-1:0]   first;
        logic                   last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first_res;
        result_t    second_res;
    } emit_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_DIG0) && (c <= CH_DIG9);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c == CH_UNDER) || is_alpha(c) || is_digit(c);
    endfunction

endpackage

[sv/ets_char_if.sv]
// ----------------------------------------------------------------------------
// ets_char_if
// Character channel: one byte or an end-of-input mark per transaction.
// ----------------------------------------------------------------------------
interface ets_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_input;

    modport source (output valid, output byte_value, output end_of_input, input ready);
    modport sink   (input valid, input byte_value, input end_of_input, output ready);
endinterface

[sv/ets_token_if.sv]
// ----------------------------------------------------------------------------
// ets_token_if
// Token channel: one token record per transaction.
// ----------------------------------------------------------------------------
interface ets_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic [7:0]  first_char;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output first_char, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input first_char, input last_of_run,
                    output ready);
endinterface

[sv/ets_scan_core.sv]
// ----------------------------------------------------------------------------
// ets_scan_core
// Scanner state and per-character token logic; emits up to two token
// records per processed character.
// ----------------------------------------------------------------------------
module ets_scan_core #(
    parameter int POSITION_WIDTH = ets_pkg::POSITION_WIDTH_DEFAULT,
    parameter int LENGTH_WIDTH   = ets_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    byte_value,
    input  logic          end_of_input,
    output ets_pkg::emit_t emit
);

    ets_pkg::scan_state_t      state_reg, state_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [POSITION_WIDTH-1:0] cur_start_reg, cur_start_next;
    logic [LENGTH_WIDTH-1:0]   cur_len_reg, cur_len_next;
    logic [7:0]                cur_first_reg, cur_first_next;

    logic [LENGTH_WIDTH-1:0]   ext_len;
    logic [63:0]               pos_w, cur_start_w;
    logic [31:0]               cur_len_w, ext_len_w;

    // restart decode of the current byte
    logic                      sk_begin;
    logic                      sk_emit;
    ets_pkg::scan_state_t      sk_state;
    ets_pkg::kind_t            sk_kind;

    logic                      flush_v, tail_v;
    ets_pkg::result_t          flush_rec, tail_rec;

    assign ext_len     = (cur_len_reg == '1) ? cur_len_reg : cur_len_reg + LENGTH_WIDTH'(1);
    assign pos_w       = 64'(pos_reg);
    assign cur_start_w = 64'(cur_start_reg);
    assign cur_len_w   = 32'(cur_len_reg);
    assign ext_len_w   = 32'(ext_len);

    always_comb
    begin
        sk_begin = 1'b1;
        sk_emit  = 1'b1;
        sk_state = ets_pkg::ST_START;
        sk_kind  = ets_pkg::KIND_ERROR;
        priority if (byte_value == ets_pkg::CH_POINT)
        begin
            sk_emit  = 1'b0;
            sk_state = ets_pkg::ST_PRE;
        end
        else if (ets_pkg::is_digit(byte_value))
        begin
            sk_emit  = 1'b0;
            sk_state = ets_pkg::ST_INT;
        end
        else if (byte_value == ets_pkg::CH_UNDER || ets_pkg::is_alpha(byte_value))
        begin
            sk_emit  = 1'b0;
            sk_state = ets_pkg::ST_SYM;
        end
        else if (ets_pkg::is_space(byte_value))
        begin
            sk_begin = 1'b0;
            sk_emit  = 1'b0;
        end
        else if (byte_value == ets_pkg::CH_PLUS || byte_value == ets_pkg::CH_MINUS)
            sk_kind = ets_pkg::KIND_SUM;
        else if (byte_value == ets_pkg::CH_STAR || byte_value == ets_pkg::CH_SLASH)
            sk_kind = ets_pkg::KIND_MUL;
        else if (byte_value == ets_pkg::CH_CARET)
            sk_kind = ets_pkg::KIND_POW;
        else if (byte_value == ets_pkg::CH_LPAREN)
            sk_kind = ets_pkg::KIND_LPAREN;
        else if (byte_value == ets_pkg::CH_RPAREN)
            sk_kind = ets_pkg::KIND_RPAREN;
        else if (byte_value == ets_pkg::CH_EQUAL)
            sk_kind = ets_pkg::KIND_EQUAL;
        else
        begin
            sk_kind  = ets_pkg::KIND_ERROR;
            sk_state = ets_pkg::ST_ERR;
        end
    end

    // next state
    always_comb
    begin
        logic restart;
        restart        = 1'b0;
        state_next     = state_reg;
        pos_next       = pos_reg;
        cur_start_next = cur_start_reg;
        cur_len_next   = cur_len_reg;
        cur_first_next = cur_first_reg;
        if (state_reg != ets_pkg::ST_END && state_reg != ets_pkg::ST_ERR)
        begin
            if (end_of_input)
            begin
                if (state_reg == ets_pkg::ST_PRE)
                    state_next = ets_pkg::ST_ERR;
                else
                    state_next = ets_pkg::ST_END;
            end
            else
            begin
                pos_next = pos_reg + POSITION_WIDTH'(1);
                unique case (state_reg)
                    ets_pkg::ST_INT:
                    begin
                        if (ets_pkg::is_digit(byte_value))
                            cur_len_next = ext_len;
                        else if (byte_value == ets_pkg::CH_POINT)
                        begin
                            cur_len_next = ext_len;
                            state_next   = ets_pkg::ST_REAL;
                        end
                        else
                            restart = 1'b1;
                    end
                    ets_pkg::ST_PRE:
                    begin
                        cur_len_next = ext_len;
                        state_next   = ets_pkg::is_digit(byte_value) ? ets_pkg::ST_REAL
                                                                     : ets_pkg::ST_ERR;
                    end
                    ets_pkg::ST_REAL:
                    begin
                        if (ets_pkg::is_digit(byte_value))
                            cur_len_next = ext_len;
                        else if (byte_value == ets_pkg::CH_POINT)
                        begin
                            cur_len_next = ext_len;
                            state_next   = ets_pkg::ST_ERR;
                        end
                        else
                            restart = 1'b1;
                    end
                    ets_pkg::ST_SYM:
                    begin
                        if (ets_pkg::is_word(byte_value))
                            cur_len_next = ext_len;
                        else
                            restart = 1'b1;
                    end
                    default:
                        restart = 1'b1;
                endcase
                if (restart)
                begin
                    state_next = ets_pkg::ST_START;
                    if (sk_begin)
                    begin
                        state_next     = sk_state;
                        cur_start_next = pos_reg;
                        cur_len_next   = LENGTH_WIDTH'(1);
                        cur_first_next = byte_value;
                    end
                end
            end
        end
    end

    // token records
    always_comb
    begin
        flush_v          = 1'b0;
        tail_v           = 1'b0;
        flush_rec.kind   = ets_pkg::KIND_NUMBER;
        flush_rec.start  = cur_start_w[31:0];
        flush_rec.length = cur_len_w[15:0];
        flush_rec.first  = cur_first_reg;
        flush_rec.last   = 1'b0;
        tail_rec.kind    = sk_kind;
        tail_rec.start   = pos_w[31:0];
        tail_rec.length  = 16'd1;
        tail_rec.first   = byte_value;
        tail_rec.last    = 1'b1;
        if (state_reg != ets_pkg::ST_END && state_reg != ets_pkg::ST_ERR)
        begin
            if (end_of_input)
            begin
                unique case (state_reg)
                    ets_pkg::ST_INT, ets_pkg::ST_REAL:
                        flush_v = 1'b1;
                    ets_pkg::ST_SYM:
                    begin
                        flush_v        = 1'b1;
                        flush_rec.kind = ets_pkg::KIND_SYMBOL;
                    end
                    ets_pkg::ST_PRE:
                    begin
                        flush_v        = 1'b1;
                        flush_rec.kind = ets_pkg::KIND_ERROR;
                    end
                    default:
                        flush_v = 1'b0;
                endcase
                tail_v          = (state_reg != ets_pkg::ST_PRE);
                tail_rec.kind   = ets_pkg::KIND_END;
                tail_rec.length = '0;
                tail_rec.first  = '0;
            end
            else
            begin
                unique case (state_reg)
                    ets_pkg::ST_INT:
                    begin
                        if (!ets_pkg::is_digit(byte_value) && byte_value != ets_pkg::CH_POINT)
                        begin
                            flush_v = 1'b1;
                            tail_v  = sk_emit;
                        end
                    end
                    ets_pkg::ST_PRE:
                    begin
                        if (!ets_pkg::is_digit(byte_value))
                        begin
                            flush_v          = 1'b1;
                            flush_rec.kind   = ets_pkg::KIND_ERROR;
                            flush_rec.length = ext_len_w[15:0];
                        end
                    end
                    ets_pkg::ST_REAL:
                    begin
                        if (byte_value == ets_pkg::CH_POINT)
                        begin
                            flush_v          = 1'b1;
                            flush_rec.kind   = ets_pkg::KIND_ERROR;
                            flush_rec.length = ext_len_w[15:0];
                        end
                        else if (!ets_pkg::is_digit(byte_value))
                        begin
                            flush_v = 1'b1;
                            tail_v  = sk_emit;
                        end
                    end
                    ets_pkg::ST_SYM:
                    begin
                        if (!ets_pkg::is_word(byte_value))
                        begin
                            flush_v        = 1'b1;
                            flush_rec.kind = ets_pkg::KIND_SYMBOL;
                            tail_v         = sk_emit;
                        end
                    end
                    default:
                        tail_v = sk_emit;
                endcase
            end
        end
        flush_rec.last = !tail_v;
    end

    always_comb
    begin
        emit.first_res  = flush_v ? flush_rec : tail_rec;
        emit.second_res = tail_rec;
        if (!step)
            emit.count = 2'd0;
        else
            emit.count = 2'(flush_v) + 2'(tail_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ets_pkg::ST_START;
            pos_reg       <= '0;
            cur_start_reg <= '0;
            cur_len_reg   <= '0;
            cur_first_reg <= '0;
        end
        else if (step)
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cur_start_reg <= cur_start_next;
            cur_len_reg   <= cur_len_next;
            cur_first_reg <= cur_first_next;
        end
    end

endmodule

[sv/ets_result_queue.sv]
// ----------------------------------------------------------------------------
// ets_result_queue
// Small token queue: takes up to two records per cycle, hands out one.
// ----------------------------------------------------------------------------
module ets_result_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ets_pkg::emit_t       emit,
    output logic                 room,
    output logic                 head_valid,
    input  logic                 head_ready,
    output ets_pkg::result_t     head
);

    localparam int PTR_W = $clog2(ets_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ets_pkg::QUEUE_DEPTH + 1);

    ets_pkg::result_t   mem [ets_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign room       = (count_reg <= CNT_W'(ets_pkg::QUEUE_DEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign pop        = head_valid && head_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(emit.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(emit.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (emit.count != 2'd0)
            mem[wr_ptr_reg] <= emit.first_res;
        if (emit.count == 2'd2)
            mem[wr_ptr_reg + PTR_W'(1)] <= emit.second_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/expression_token_scanner.sv]
// ----------------------------------------------------------------------------
// expression_token_scanner
// Splits a byte stream into arithmetic expression tokens.
// ----------------------------------------------------------------------------
//   channel  dir  transaction
//   chars    in   one byte_value, or end_of_input
//   tokens   out  one token record, last_of_run marks the final one per byte
//
// One byte per cycle while the queue has room: input register -> scanner ->
// 4-entry token queue. The tokens of a byte are registered in the queue.
// A byte is taken whenever the queue has room for two tokens; the sustained
// rate is one byte per cycle while tokens average at most one per byte and
// the token sink is always ready.
// Reset clears scanner state, the input valid flag and the queue pointers;
// after END or an error the scanner takes bytes and drops them until reset.
module expression_token_scanner #(
    parameter int POSITION_WIDTH = ets_pkg::POSITION_WIDTH_DEFAULT,
    parameter int LENGTH_WIDTH   = ets_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    ets_char_if.sink    chars,
    ets_token_if.source tokens
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_eoi_reg;
    logic             room;
    logic             advance;
    ets_pkg::emit_t   emit;
    ets_pkg::result_t head;

    assign advance     = in_valid_reg && room;
    assign chars.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (chars.ready)
            in_valid_reg <= chars.valid;
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            in_byte_reg <= chars.byte_value;
            in_eoi_reg  <= chars.end_of_input;
        end
    end

    ets_scan_core #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .LENGTH_WIDTH   (LENGTH_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .byte_value   (in_byte_reg),
        .end_of_input (in_eoi_reg),
        .emit         (emit)
    );

    ets_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (emit),
        .room       (room),
        .head_valid (tokens.valid),
        .head_ready (tokens.ready),
        .head       (head)
    );

    assign tokens.token_kind   = head.kind;
    assign tokens.token_start  = head.start;
    assign tokens.token_length = head.length;
    assign tokens.first_char   = head.first;
    assign tokens.last_of_run  = head.last;

endmodule
